// ----- rtl/harmonic_bond_force_core_assert.svh -----
// ----------------------------------------------------------------------------
// harmonic bond force core assertion macros
// concurrent assertion shorthands used by harmonic_bond_force_core.sv
// ----------------------------------------------------------------------------
`ifndef HARMONIC_BOND_FORCE_CORE_ASSERT_SVH
`define HARMONIC_BOND_FORCE_CORE_ASSERT_SVH

// same-cycle implication
`define HBF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hbf assertion failed");

// next-cycle implication
`define HBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hbf assertion failed");

`endif

// ----- rtl/hbf_pkg.sv -----
// ----------------------------------------------------------------------------
// hbf_pkg
// widths, types and helper functions of the harmonic bond force core
// ----------------------------------------------------------------------------
package hbf_pkg;

    localparam int HBF_FRAC   = 16;
    localparam int HBF_DIMS   = 3;

    localparam int POS_W      = 32;
    localparam int COEF_W     = 32;
    localparam int IDX_W      = 16;
    localparam int OUT_W      = 48;

    localparam int D_W        = POS_W + 1;
    localparam int SQ_W       = 2 * D_W - 1;
    localparam int SUM_W      = SQ_W + 2;
    localparam int R_W        = (SUM_W + 1) / 2;
    localparam int ST_W       = R_W + 1;
    localparam int KD_W       = COEF_W + R_W;
    localparam int P_W        = KD_W + R_W;
    localparam int FN_W       = KD_W + D_W;
    localparam int DEN_W      = R_W + HBF_FRAC;
    localparam int Q_W        = OUT_W + 1;
    localparam int DIV_LAT    = Q_W + 1;

    localparam int IN_W       = 6 * POS_W + 2 * COEF_W + 2 * IDX_W;
    localparam int OUT_DATA_W = 5 * OUT_W + 2 * IDX_W;

    typedef struct packed {
        logic [2:0][D_W-1:0] mag;
        logic [2:0]          neg;
        logic [COEF_W-1:0]   r0;
        logic [COEF_W-1:0]   k;
        logic [IDX_W-1:0]    idx_i;
        logic [IDX_W-1:0]    idx_j;
        logic [R_W-1:0]      r;
        logic [R_W-1:0]      dmag;
        logic                sneg;
        logic [KD_W-1:0]     kd;
    } t_ctx;

    typedef struct packed {
        logic [OUT_W-1:0] energy;
        logic [OUT_W-1:0] virial;
        logic [2:0]       fneg;
        logic             zf;
        logic             degen;
        logic [IDX_W-1:0] idx_i;
        logic [IDX_W-1:0] idx_j;
    } t_side;

    typedef struct packed {
        logic [63:0]     pa;
        logic [63:0]     pb;
        logic [KD_W-65:0] pc_hi;
        logic [31:0]     pc_lo;
        logic [KD_W+1:0] pd;
    } t_pp;

    typedef struct packed {
        logic             degen;
        logic [IDX_W-1:0] idx_j;
        logic [IDX_W-1:0] idx_i;
        logic [OUT_W-1:0] virial;
        logic [OUT_W-1:0] energy;
        logic [OUT_W-1:0] fz;
        logic [OUT_W-1:0] fy;
        logic [OUT_W-1:0] fx;
    } t_res;

    // partial products of kd times a 34-bit operand split as 32 + 2 bits
    function automatic t_pp mul_parts(input logic [KD_W-1:0] kd, input logic [31:0] xl,
                                      input logic [1:0] xh);
        t_pp p;
        logic [KD_W-33:0] hi_prod;
        p.pa    = kd[31:0] * xl;
        p.pb    = kd[63:32] * xl;
        hi_prod = kd[KD_W-1:64] * xl;
        p.pc_hi = hi_prod[KD_W-33:32];
        p.pc_lo = hi_prod[31:0];
        p.pd    = kd * xh;
        return p;
    endfunction

    function automatic logic [P_W-1:0] pp_sum(input t_pp p);
        return P_W'(p.pa) + (P_W'(p.pb) << 32) + (P_W'({p.pc_hi, p.pc_lo}) << 64)
               + (P_W'(p.pd) << 32);
    endfunction

    function automatic logic [OUT_W-1:0] sat_s48(input logic [P_W-1:0] mag, input logic neg);
        logic [OUT_W-1:0] lim;
        logic [OUT_W-1:0] m;
        lim = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        m   = (mag > P_W'(lim)) ? lim : mag[OUT_W-1:0];
        return neg ? (~m + 1'b1) : m;
    endfunction

endpackage

// ----- rtl/harmonic_bond_force_core.sv -----
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined square root and dividers
// the 34-stage square root and the 50-stage force dividers set the latency
// a stalled output holds up to two results before o_s_tready drops
// reset: synchronous active-low i_rst_n clears all valid bits, including those of the output buffer
// ----------------------------------------------------------------------------
// harmonic_bond_force_core
// force, energy and virial of one harmonic bond per item, deep pipeline
// ----------------------------------------------------------------------------
`include "harmonic_bond_force_core_assert.svh"

module harmonic_bond_force_core
    import hbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z, rest_length,
    // stiffness, index_i, index_j
    input  logic [IN_W-1:0]       i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // force_x, force_y, force_z, bond_energy, bond_virial, out_index_i, out_index_j
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // degenerate
    output logic [0:0]            o_m_tuser
);

    logic w_en;

    // stage 1: separation
    t_ctx n_ctx1, r_ctx1, r_ctx2, r_ctx3;
    logic r_v1, r_v2, r_v3;

    always_comb begin
        logic signed [D_W-1:0] d;
        logic [POS_W-1:0]      pi;
        logic [POS_W-1:0]      pj;
        n_ctx1 = '0;
        for (int c = 0; c < 3; c++) begin
            pi = i_s_tdata[c*POS_W +: POS_W];
            pj = i_s_tdata[(3+c)*POS_W +: POS_W];
            d  = {pj[POS_W-1], pj} - {pi[POS_W-1], pi};
            if (c < HBF_DIMS) begin
                n_ctx1.neg[c] = d[D_W-1];
                n_ctx1.mag[c] = d[D_W-1] ? D_W'(-d) : D_W'(d);
            end
        end
        n_ctx1.r0    = i_s_tdata[6*POS_W +: COEF_W];
        n_ctx1.k     = i_s_tdata[6*POS_W+COEF_W +: COEF_W];
        n_ctx1.idx_i = i_s_tdata[6*POS_W+2*COEF_W +: IDX_W];
        n_ctx1.idx_j = i_s_tdata[6*POS_W+2*COEF_W+IDX_W +: IDX_W];
    end

    // stage 2: squares, stage 3: sum
    logic [SQ_W-1:0]  n_sq [3];
    logic [SQ_W-1:0]  r_sq [3];
    logic [SUM_W-1:0] r_sum;

    always_comb begin
        logic [2*POS_W-1:0] lsq;
        for (int c = 0; c < 3; c++) begin
            lsq     = r_ctx1.mag[c][POS_W-1:0] * r_ctx1.mag[c][POS_W-1:0];
            n_sq[c] = {r_ctx1.mag[c][D_W-1], lsq};
        end
    end

    // square root with its side line
    logic           w_sv;
    logic [R_W-1:0] w_root;
    t_ctx           r_sa [R_W];

    hbf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_op    ((2*R_W)'(r_sum)),
        .o_valid (w_sv),
        .o_root  (w_root)
    );

    // stage 4: stretch, 5: kd partials, 6: kd, 7: product partials, 8: products
    t_ctx n_ctx4, r_ctx4, r_ctx5, n_ctx6, r_ctx6, r_ctx7, r_ctx8;
    logic r_v4, r_v5, r_v6, r_v7, r_v8;
    logic [63:0]       r_kp0;
    logic [R_W-1:0]    r_kp1;
    t_pp               r_pf [3];
    t_pp               r_pe;
    t_pp               r_pv;
    logic [FN_W-1:0]   r_nf [3];
    logic [P_W-1:0]    r_pes;
    logic [P_W-1:0]    r_pvs;

    always_comb begin
        logic [ST_W-1:0] st;
        n_ctx4      = r_sa[R_W-1];
        n_ctx4.r    = w_root;
        st          = ST_W'(w_root) - ST_W'(r_sa[R_W-1].r0);
        n_ctx4.sneg = st[ST_W-1];
        n_ctx4.dmag = st[ST_W-1] ? R_W'(-st) : R_W'(st);
    end

    always_comb begin
        n_ctx6    = r_ctx5;
        n_ctx6.kd = KD_W'(r_kp0) + (KD_W'(r_kp1) << 32);
    end

    // side values computed as items enter the dividers
    t_side            n_sb;
    t_side            r_sb [DIV_LAT];
    logic [DEN_W-1:0] w_den;

    always_comb begin
        logic [P_W-1:0] esh;
        esh          = r_pes >> (2*HBF_FRAC + 1);
        n_sb.energy  = (|(esh >> OUT_W)) ? {OUT_W{1'b1}} : esh[OUT_W-1:0];
        n_sb.virial  = sat_s48(r_pvs >> (2*HBF_FRAC), r_ctx8.sneg);
        n_sb.fneg    = {3{r_ctx8.sneg}} ^ r_ctx8.neg;
        n_sb.zf      = (r_ctx8.r == '0) || (r_ctx8.kd == '0);
        n_sb.degen   = (r_ctx8.r == '0);
        n_sb.idx_i   = r_ctx8.idx_i;
        n_sb.idx_j   = r_ctx8.idx_j;
    end

    assign w_den = {r_ctx8.r, {HBF_FRAC{1'b0}}};

    logic [2:0]     w_dv;
    logic [Q_W-1:0] w_q [3];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        hbf_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r_v8),
            .i_num   (r_nf[g]),
            .i_den   (w_den),
            .o_valid (w_dv[g]),
            .o_quot  (w_q[g])
        );
    end

    // final saturation
    t_res  n_res;
    t_res  w_out;
    t_side w_sb;

    assign w_sb = r_sb[DIV_LAT-1];

    always_comb begin
        n_res.fx     = w_sb.zf ? '0 : sat_s48(P_W'(w_q[0]), w_sb.fneg[0]);
        n_res.fy     = w_sb.zf ? '0 : sat_s48(P_W'(w_q[1]), w_sb.fneg[1]);
        n_res.fz     = w_sb.zf ? '0 : sat_s48(P_W'(w_q[2]), w_sb.fneg[2]);
        n_res.energy = w_sb.energy;
        n_res.virial = w_sb.virial;
        n_res.idx_i  = w_sb.idx_i;
        n_res.idx_j  = w_sb.idx_j;
        n_res.degen  = w_sb.degen;
    end

    hbf_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (&w_dv),
        .i_data  (n_res),
        .o_en    (w_en),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_out)
    );

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= w_sv;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctx1 <= n_ctx1;
            r_ctx2 <= r_ctx1;
            r_ctx3 <= r_ctx2;
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= n_sq[c];
            end
            r_sum  <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_sa[0] <= r_ctx3;
            for (int s = 1; s < R_W; s++) begin
                r_sa[s] <= r_sa[s-1];
            end
            r_ctx4 <= n_ctx4;
            r_kp0  <= r_ctx4.k * r_ctx4.dmag[31:0];
            r_kp1  <= r_ctx4.k * r_ctx4.dmag[R_W-1:32];
            r_ctx5 <= r_ctx4;
            r_ctx6 <= n_ctx6;
            for (int c = 0; c < 3; c++) begin
                r_pf[c] <= mul_parts(r_ctx6.kd, r_ctx6.mag[c][31:0],
                                     {1'b0, r_ctx6.mag[c][D_W-1]});
            end
            r_pe   <= mul_parts(r_ctx6.kd, r_ctx6.dmag[31:0], r_ctx6.dmag[R_W-1:32]);
            r_pv   <= mul_parts(r_ctx6.kd, r_ctx6.r[31:0], r_ctx6.r[R_W-1:32]);
            r_ctx7 <= r_ctx6;
            for (int c = 0; c < 3; c++) begin
                r_nf[c] <= FN_W'(pp_sum(r_pf[c]));
            end
            r_pes  <= pp_sum(r_pe);
            r_pvs  <= pp_sum(r_pv);
            r_ctx8 <= r_ctx7;
            r_sb[0] <= n_sb;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_sb[s] <= r_sb[s-1];
            end
        end
    end

    assign o_s_tready = w_en;
    assign o_m_tdata  = {w_out.idx_j, w_out.idx_i, w_out.virial, w_out.energy,
                         w_out.fz, w_out.fy, w_out.fx};
    assign o_m_tuser  = w_out.degen;

    `HBF_ASSERT_IMPL(a_degen_zero_force, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], (o_m_tdata[3*OUT_W-1:0] == '0) && (o_m_tdata[5*OUT_W-1:4*OUT_W] == '0))
    `HBF_ASSERT_NEXT(a_stall_holds_s1, i_clk, i_rst_n, r_v1 && !w_en, r_v1)
    `HBF_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, !o_s_tready && i_m_tready, o_s_tready)

endmodule

// ----- rtl/hbf_sqrt.sv -----
// ----------------------------------------------------------------------------
// hbf_sqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module hbf_sqrt
    import hbf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [2*R_W-1:0] i_op,
    output logic             o_valid,
    output logic [R_W-1:0]   o_root
);

    localparam int REM_W = R_W + 2;

    logic             r_v    [R_W];
    logic [REM_W-1:0] r_rem  [R_W];
    logic [R_W-1:0]   r_root [R_W];
    logic [2*R_W-1:0] r_op   [R_W];

    for (genvar g = 0; g < R_W; g++) begin : g_stage
        logic             v_in;
        logic [REM_W-1:0] rem_in;
        logic [R_W-1:0]   root_in;
        logic [2*R_W-1:0] op_in;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             ge;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign op_in   = i_op;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign op_in   = r_op[g-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], op_in[2*R_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? (rem_sh - trial) : rem_sh;
                r_root[g] <= {root_in[R_W-2:0], ge};
                r_op[g]   <= {op_in[2*R_W-3:0], 2'b00};
            end
        end
    end

    assign o_valid = r_v[R_W-1];
    assign o_root  = r_root[R_W-1];

endmodule

// ----- rtl/hbf_div.sv -----
// ----------------------------------------------------------------------------
// hbf_div
// pipelined restoring divider, quotient clamped to all ones on overflow
// ----------------------------------------------------------------------------
module hbf_div
    import hbf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [FN_W-1:0]  i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quot
);

    localparam int HI_W = FN_W - Q_W;

    logic [HI_W-1:0]  hi;
    logic             ovf;

    logic             r_pv;
    logic [DEN_W-1:0] r_prem;
    logic [Q_W-1:0]   r_plo;
    logic [DEN_W-1:0] r_pden;
    logic             r_povf;

    logic             r_v   [Q_W];
    logic [DEN_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_lo  [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic             r_ovf [Q_W];

    assign hi  = i_num[FN_W-1:Q_W];
    assign ovf = ({{DEN_W{1'b0}}, hi} >= {{HI_W{1'b0}}, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prem <= DEN_W'(hi);
            r_plo  <= i_num[Q_W-1:0];
            r_pden <= i_den;
            r_povf <= ovf;
        end
    end

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        logic             v_in;
        logic [DEN_W-1:0] rem_in;
        logic [Q_W-1:0]   lo_in;
        logic [Q_W-1:0]   q_in;
        logic [DEN_W-1:0] den_in;
        logic             ovf_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (g == 0) begin : g_first
            assign v_in   = r_pv;
            assign rem_in = r_prem;
            assign lo_in  = r_plo;
            assign q_in   = '0;
            assign den_in = r_pden;
            assign ovf_in = r_povf;
        end else begin : g_next
            assign v_in   = r_v[g-1];
            assign rem_in = r_rem[g-1];
            assign lo_in  = r_lo[g-1];
            assign q_in   = r_q[g-1];
            assign den_in = r_den[g-1];
            assign ovf_in = r_ovf[g-1];
        end

        assign trial = {rem_in, lo_in[Q_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_lo[g]  <= {lo_in[Q_W-2:0], 1'b0};
                r_q[g]   <= {q_in[Q_W-2:0], ge};
                r_den[g] <= den_in;
                r_ovf[g] <= ovf_in;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quot  = r_ovf[Q_W-1] ? {Q_W{1'b1}} : r_q[Q_W-1];

endmodule

// ----- rtl/hbf_skid.sv -----
// ----------------------------------------------------------------------------
// hbf_skid
// output register with one skid entry, freezes the pipeline when full
// ----------------------------------------------------------------------------
module hbf_skid
    import hbf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_res i_data,
    output logic o_en,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_data
);

    logic r_ov;
    logic r_sv;
    t_res r_out;
    t_res r_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (i_ready) begin
                r_sv <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_ov || i_ready) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (i_ready) begin
                r_out <= r_sk;
            end
        end else if (i_valid) begin
            if (!r_ov || i_ready) begin
                r_out <= i_data;
            end else begin
                r_sk <= i_data;
            end
        end
    end

    assign o_en    = !r_sv;
    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// streams bonds through the harmonic bond force core and compares every
// result against a predictor of force, energy, virial and degenerate flag
// ----------------------------------------------------------------------------
module tb_top;
    import hbf_pkg::*;

    localparam int LATENCY   = 92;
    localparam int MAX_CYC   = 1500000;
    localparam logic [47:0] MAX_S = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] MAX_U = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [47:0] fx, fy, fz, energy, virial;
        logic [15:0] idx_i, idx_j;
        logic        degen;
    } t_bond_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_W-1:0]       i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [0:0]            o_m_tuser;

    t_bond_res expected_bonds[$];
    int        err_cnt = 0;
    int        cyc = 0;
    bit        rx_idle_en = 1'b0;
    int        rx_hold = 0;
    bit        rx_long_req = 1'b0;
    bit        rx_long_ack = 1'b0;
    bit        tx_idle_en = 1'b0;

    harmonic_bond_force_core uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= MAX_CYC) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [47:0] sat_signed(logic [127:0] mag, bit neg);
        logic [127:0] lim;
        lim = neg ? 128'(MAX_S) + 1 : 128'(MAX_S);
        if (mag > lim) mag = lim;
        return neg ? 48'(-mag[47:0]) : mag[47:0];
    endfunction

    function automatic t_bond_res predict_bond(logic [IN_W-1:0] d);
        t_bond_res   res;
        logic signed [32:0] dl [3];
        logic [32:0] mag [3];
        bit          neg [3];
        logic [127:0] sum, kd, f, e, v, t;
        logic [63:0] r, rr, r0, k, dmag;
        bit          sneg;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            dl[i] = $signed(d[(3+i)*32 +: 32]) - $signed(d[i*32 +: 32]);
            neg[i] = dl[i] < 0;
            mag[i] = neg[i] ? -dl[i] : dl[i];
            sum += 128'(mag[i]) * 128'(mag[i]);
        end
        r = 0;
        for (int b = 33; b >= 0; b--) begin
            rr = r | (64'd1 << b);
            t = 128'(rr) * 128'(rr);
            if (t <= sum) r = rr;
        end
        r0 = d[6*32 +: 32];
        k  = d[7*32 +: 32];
        sneg = r < r0;
        dmag = sneg ? r0 - r : r - r0;
        kd = 128'(k) * 128'(dmag);
        res.fx = 0; res.fy = 0; res.fz = 0;
        for (int i = 0; i < 3; i++) begin
            if (r != 0 && mag[i] != 0 && dmag != 0 && k != 0) begin
                f = (kd * 128'(mag[i])) / (128'(r) << 16);
                t = 128'(sat_signed(f, sneg != neg[i]));
                if (i == 0) res.fx = t[47:0];
                else if (i == 1) res.fy = t[47:0];
                else res.fz = t[47:0];
            end
        end
        e = (kd * 128'(dmag)) >> 33;
        res.energy = (e > 128'(MAX_U)) ? MAX_U : e[47:0];
        if (r == 0 || dmag == 0 || k == 0) res.virial = 0;
        else begin
            v = (kd * 128'(r)) >> 32;
            res.virial = sat_signed(v, sneg);
        end
        res.idx_i = d[8*32 +: 16];
        res.idx_j = d[8*32+16 +: 16];
        res.degen = (r == 0);
        return res;
    endfunction

    // rx ready with random stalls, optional long hold
    always @(negedge i_clk) begin
        if (rx_long_req != rx_long_ack) begin
            rx_long_ack <= rx_long_req;
            rx_hold <= 399;
            i_m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_hold <= $urandom_range(0, 16);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_bond_res exp_r;
        t_bond_res got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.fx = o_m_tdata[0 +: 48];
            got.fy = o_m_tdata[48 +: 48];
            got.fz = o_m_tdata[96 +: 48];
            got.energy = o_m_tdata[144 +: 48];
            got.virial = o_m_tdata[192 +: 48];
            got.idx_i = o_m_tdata[240 +: 16];
            got.idx_j = o_m_tdata[256 +: 16];
            got.degen = o_m_tuser[0];
            if (expected_bonds.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected item at cycle %0d", cyc);
            end else begin
                exp_r = expected_bonds.pop_front();
                if (got != exp_r) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("mismatch: exp %h %h %h %h %h %h %h %b",
                                 exp_r.fx, exp_r.fy, exp_r.fz, exp_r.energy, exp_r.virial,
                                 exp_r.idx_i, exp_r.idx_j, exp_r.degen);
                        $display("          got %h %h %h %h %h %h %h %b",
                                 got.fx, got.fy, got.fz, got.energy, got.virial,
                                 got.idx_i, got.idx_j, got.degen);
                    end
                end
            end
        end
    end

    task automatic send_bond(logic [IN_W-1:0] d);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_bonds = {expected_bonds, predict_bond(d)};
        @(negedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] pack_bond(logic [31:0] ix, iy, iz, jx, jy, jz,
                                                  logic [31:0] r0, k, logic [15:0] a, b);
        return {b, a, k, r0, jz, jy, jx, iz, iy, ix};
    endfunction

    function automatic logic [IN_W-1:0] rand_bond();
        logic [31:0] p [6];
        logic [31:0] r0, k;
        int sc;
        sc = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) begin
            p[i] = $urandom();
            case (sc)
                0: p[i+3] = p[i] + 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
                1: p[i+3] = p[i] + ($urandom() >>> $urandom_range(0, 31));
                2: p[i+3] = $urandom();
                default: p[i+3] = ($urandom_range(0, 9) == 0) ? p[i] : $urandom();
            endcase
        end
        r0 = ($urandom_range(0, 1)) ? $urandom() : $urandom_range(0, 5 << 16);
        k  = $urandom() >> $urandom_range(0, 31);
        return pack_bond(p[0], p[1], p[2], p[3], p[4], p[5], r0, k,
                         16'($urandom()), 16'($urandom()));
    endfunction

    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (expected_bonds.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_bond(pack_bond(0, 0, 0, 0, 0, 0, 0, 0, 16'd0, 16'd0));
        send_bond(pack_bond(5, 6, 7, 5, 6, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd0));
        send_bond(pack_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            0, 32'hFFFF_FFFF, 16'd1, 16'hFFFF));
        send_bond(pack_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hAAAA, 16'h5555));
        send_bond(pack_bond(0, 0, 0, 32'h1_0000, 0, 0, 32'h1_0000, 32'h10_0000, 16'd2, 16'd3));
        send_bond(pack_bond(0, 0, 0, 32'h2_0000, 0, 0, 32'h1_0000, 32'h10_0000, 16'd2, 16'd3));
        send_bond(pack_bond(0, 0, 0, 0, 32'hFFFF_0000, 0, 32'h3_0000, 32'h1_0000, 16'd4, 16'd5));
        send_bond(pack_bond(0, 0, 0, 0, 0, 32'h3_0000, 0, 32'h1_0000, 16'd6, 16'd7));
        send_bond(pack_bond(0, 0, 0, 1, 1, 1, 0, 32'h1, 16'd8, 16'd9));
        send_bond(pack_bond(1, 2, 3, 4, 5, 6, 7, 0, 16'd10, 16'd11));
        send_bond(pack_bond(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                            32'hEDCB_A987, 32'h6543_2100, 32'hF0F0_F0F0,
                            32'h5555_5555, 32'hAAAA_AAAA, 16'h1234, 16'hFEDC));
        send_bond(pack_bond(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 16'd12, 16'd13));
    endtask

    task automatic test_random_stalls(int n);
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        repeat (n) send_bond(rand_bond());
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_long_req = ~rx_long_req;
        repeat (200) send_bond(rand_bond());
        wait_drain();
    endtask

    task automatic test_full_rate(int n);
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        repeat (n) send_bond(rand_bond());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_stalls(600);
        test_backpressure();
        test_random_stalls(250);
        test_full_rate(300);
        wait_drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (err_cnt == 0 && expected_bonds.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
